// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files that check themselves.
// All checks sample on the rising edge of clock and are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/btpw_pkg.sv =====
// ----------------------------------------------------------------------------
// btpw_pkg
// Types, register indexes, reset values and the 3x5 glyph table of the
// bitmap text pixel writer.
// ----------------------------------------------------------------------------
`default_nettype none

package btpw_pkg;

   typedef logic signed [15:0] coord_type;
   typedef logic [15:0]        color_type;
   typedef logic [17:0]        pix_addr_type;
   typedef logic [9:0]         dim_type;
   typedef logic [4:0]         cell_type;
   typedef logic [2:0]         csr_addr_type;
   typedef logic [9:0]         csr_data_type;
   typedef logic [14:0]        glyph_type;

   // Offset of one pixel inside the glyph cell, already scaled.
   typedef struct packed {
      logic [2:0] dx;
      logic [3:0] dy;
   } pix_ofs_type;

   localparam csr_addr_type REG_TARGET_WIDTH  = 3'd0;
   localparam csr_addr_type REG_TARGET_HEIGHT = 3'd1;
   localparam csr_addr_type REG_DOUBLE_SIZE   = 3'd2;
   localparam csr_addr_type REG_CELL_WIDTH    = 3'd3;
   localparam csr_addr_type REG_CELL_HEIGHT   = 3'd4;

   localparam dim_type  RST_TARGET_WIDTH  = 10'd128;
   localparam dim_type  RST_TARGET_HEIGHT = 10'd128;
   localparam cell_type RST_CELL_WIDTH    = 5'd4;
   localparam cell_type RST_CELL_HEIGHT   = 5'd6;

   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_CURSOR = 1'b1;

   localparam logic [7:0] NEWLINE_CODE  = 8'd10;
   localparam glyph_type  UNKNOWN_GLYPH = 15'h7fff;

   localparam logic [15:0] GLYPH_ROM [128] = '{
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h2092, 16'h002d, 16'h5f7d, 16'h2f9f, 16'h52a5, 16'h7adb, 16'h0012,
      16'h224a, 16'h2922, 16'h55d5, 16'h05d0, 16'h1400, 16'h01c0, 16'h2000, 16'h1494,
      16'h7b6f, 16'h7493, 16'h73e7, 16'h79a7, 16'h49ed, 16'h79cf, 16'h7bc9, 16'h4927,
      16'h7bef, 16'h49ef, 16'h0410, 16'h1410, 16'h4454, 16'h0e38, 16'h1511, 16'h21a7,
      16'h636a, 16'h5bef, 16'h7aef, 16'h624e, 16'h7b6b, 16'h72cf, 16'h12cf, 16'h7a4e,
      16'h5bed, 16'h7497, 16'h3497, 16'h5aed, 16'h7249, 16'h5b7f, 16'h5b6b, 16'h3b6e,
      16'h13ef, 16'h676a, 16'h5aef, 16'h39ce, 16'h2497, 16'h6b6d, 16'h2b6d, 16'h7f6d,
      16'h5aad, 16'h79ed, 16'h72a7, 16'h324b, 16'h4491, 16'h6926, 16'h002a, 16'h7000,
      16'h0022, 16'h5f78, 16'h7ad8, 16'h7278, 16'h3b58, 16'h72f8, 16'h12f8, 16'h7a78,
      16'h5f68, 16'h74b8, 16'h34b8, 16'h5ae8, 16'h7248, 16'h5bf8, 16'h5b58, 16'h3b70,
      16'h1f78, 16'h6750, 16'h5778, 16'h3870, 16'h24b8, 16'h6b68, 16'h2f68, 16'h7f68,
      16'h5aa8, 16'h79e8, 16'h7338, 16'h64d6, 16'h2492, 16'h3593, 16'h03e0, 16'h0550
   };

endpackage

`default_nettype wire

// ===== rtl/btpw_req_if.sv =====
// ----------------------------------------------------------------------------
// btpw_req_if
// Character request channel: valid/ready plus one character and its context.
// ----------------------------------------------------------------------------
`default_nettype none

interface btpw_req_if import btpw_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      start_of_text;
   coord_type origin_x;
   coord_type origin_y;
   color_type ink_color;
   logic [7:0] character;

   modport source (
      output valid, start_of_text, origin_x, origin_y, ink_color, character,
      input  ready
   );
   modport sink (
      input  valid, start_of_text, origin_x, origin_y, ink_color, character,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/btpw_rsp_if.sv =====
// ----------------------------------------------------------------------------
// btpw_rsp_if
// Result channel: pixel writes and the closing cursor report.
// ----------------------------------------------------------------------------
`default_nettype none

interface btpw_rsp_if import btpw_pkg::*; ();
   logic         valid;
   logic         ready;
   logic         kind;
   pix_addr_type pixel_address;
   color_type    pixel_color;
   coord_type    cursor_column;
   logic         last;

   modport source (
      output valid, kind, pixel_address, pixel_color, cursor_column, last,
      input  ready
   );
   modport sink (
      input  valid, kind, pixel_address, pixel_color, cursor_column, last,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/btpw_csr_if.sv =====
// ----------------------------------------------------------------------------
// btpw_csr_if
// Register write channel: valid/ready, register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface btpw_csr_if import btpw_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_addr_type addr;
   csr_data_type wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/btpw_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// btpw_pixel_unit
// Shared pixel unit: offsets the cursor, clips to the target and forms the
// linear framebuffer address.
// ----------------------------------------------------------------------------
`default_nettype none

module btpw_pixel_unit import btpw_pkg::*; (
   input  coord_type    base_x,
   input  coord_type    base_y,
   input  pix_ofs_type  ofs,
   input  dim_type      target_width,
   input  dim_type      target_height,
   output logic         hit,
   output pix_addr_type addr
);

   logic signed [16:0] pos_x;
   logic signed [16:0] pos_y;
   logic [19:0]        row_base;
   logic [20:0]        lin_addr;

   always_comb begin
      pos_x = 17'(base_x) + 17'(signed'({1'b0, ofs.dx}));
      pos_y = 17'(base_y) + 17'(signed'({1'b0, ofs.dy}));
      hit = !pos_x[16] && !pos_y[16]
            && (pos_x[15:0] < {6'd0, target_width})
            && (pos_y[15:0] < {6'd0, target_height});
      row_base = pos_y[9:0] * target_width;
      lin_addr = {1'b0, row_base} + {11'd0, pos_x[9:0]};
      addr = lin_addr[17:0];
   end

endmodule

`default_nettype wire

// ===== rtl/bitmap_text_pixel_writer_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_text_pixel_writer_top
// Turns characters into framebuffer pixel writes with a 3x5 bitmap font.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  carries one character request; it is taken while the writer is
//           idle. start_of_text loads origin_x/origin_y into the cursor first.
//   rsp_ch  returns zero or more pixel writes (kind 0) and then one cursor
//           report (kind 1, last 1) for every request.
//   csr_ch  writes target_width, target_height, double_size, cell_width and
//           cell_height; always ready, write only while no request is open.
// Glyph walk:
//   A glyph is walked through the shared pixel unit one bit per cycle at
//   single size while the output register can take a result; in double size
//   a set bit takes one step per 2x2 sub-pixel. A newline skips the walk and
//   goes straight to the cursor report. Every result is loaded into the
//   output register before it is offered on rsp_ch.
// Reset clears the cursor, restores the register defaults and empties the
// output register. A stalled receiver holds the output register and freezes
// the glyph walk until the pending result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_text_pixel_writer_top import btpw_pkg::*; #(
   parameter int unsigned GLYPH_COUNT = 128
) (
   input  wire logic   clock,
   input  wire logic   reset,
   btpw_req_if.sink    req_ch,
   btpw_rsp_if.source  rsp_ch,
   btpw_csr_if.sink    csr_ch
);

   `include "assert_macros.svh"

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DRAW   = 2'd1;
   localparam logic [1:0] ST_REPORT = 2'd2;

   localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_COUNT);

   // configuration registers
   dim_type   width_ff, height_ff;
   logic      double_ff;
   cell_type  cell_w_ff, cell_h_ff;

   // sequencer and cursor state
   logic [1:0] state_ff, state_in;
   coord_type  cursor_x_ff, cursor_x_in;
   coord_type  cursor_y_ff, cursor_y_in;
   coord_type  line_x_ff, line_x_in;
   glyph_type  shape_ff, shape_in;
   logic       newline_ff, newline_in;
   logic [1:0] col_ff, col_in;
   logic [2:0] row_ff, row_in;
   logic [1:0] sub_ff, sub_in;
   color_type  ink_ff, ink_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_kind_ff, rsp_kind_in;
   pix_addr_type rsp_addr_ff, rsp_addr_in;
   color_type    rsp_color_ff, rsp_color_in;
   coord_type    rsp_column_ff, rsp_column_in;
   logic         rsp_last_ff, rsp_last_in;

   logic         can_emit;
   logic         step_done;
   glyph_type    glyph_sel;
   pix_ofs_type  pix_ofs;
   logic         pix_hit;
   pix_addr_type pix_addr;
   logic [5:0]   adv_x, adv_y;
   logic signed [17:0] sum_x, sum_y;
   coord_type    sat_x, sat_y;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.kind          = rsp_kind_ff;
   assign rsp_ch.pixel_address = rsp_addr_ff;
   assign rsp_ch.pixel_color   = rsp_color_ff;
   assign rsp_ch.cursor_column = rsp_column_ff;
   assign rsp_ch.last          = rsp_last_ff;

   // the output register is free now or will be at this edge
   assign can_emit = !rsp_valid_ff || rsp_ch.ready;

   // glyph lookup: table below 128, blank up to the glyph count, solid above
   always_comb begin
      if ({1'b0, req_ch.character} < GLYPH_LIMIT) begin
         if (!req_ch.character[7]) begin
            glyph_sel = GLYPH_ROM[req_ch.character[6:0]][14:0];
         end else begin
            glyph_sel = '0;
         end
      end else begin
         glyph_sel = UNKNOWN_GLYPH;
      end
   end

   // scaled offset of the current sub-pixel inside the cell
   always_comb begin
      if (double_ff) begin
         pix_ofs.dx = {col_ff, sub_ff[0]};
         pix_ofs.dy = {row_ff, sub_ff[1]};
      end else begin
         pix_ofs.dx = {1'b0, col_ff};
         pix_ofs.dy = {1'b0, row_ff};
      end
   end

   btpw_pixel_unit u_pixel (
      .base_x        (cursor_x_ff),
      .base_y        (cursor_y_ff),
      .ofs           (pix_ofs),
      .target_width  (width_ff),
      .target_height (height_ff),
      .hit           (pix_hit),
      .addr          (pix_addr)
   );

   // cursor advance with saturation to the signed 16-bit range
   always_comb begin
      adv_x = double_ff ? {cell_w_ff, 1'b0} : {1'b0, cell_w_ff};
      adv_y = double_ff ? {cell_h_ff, 1'b0} : {1'b0, cell_h_ff};
      sum_x = 18'(cursor_x_ff) + 18'(signed'({1'b0, adv_x}));
      sum_y = 18'(cursor_y_ff) + 18'(signed'({1'b0, adv_y}));
      if (sum_x > 18'sd32767) begin
         sat_x = 16'sh7fff;
      end else if (sum_x < -18'sd32768) begin
         sat_x = 16'sh8000;
      end else begin
         sat_x = sum_x[15:0];
      end
      if (sum_y > 18'sd32767) begin
         sat_y = 16'sh7fff;
      end else if (sum_y < -18'sd32768) begin
         sat_y = 16'sh8000;
      end else begin
         sat_y = sum_y[15:0];
      end
   end

   // a clear bit, single size or the last 2x2 sub-pixel finishes a glyph bit
   assign step_done = !shape_ff[0] || !double_ff || (sub_ff == 2'd3);

   always_comb begin
      state_in      = state_ff;
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      line_x_in     = line_x_ff;
      shape_in      = shape_ff;
      newline_in    = newline_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      sub_in        = sub_ff;
      ink_in        = ink_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_column_in = rsp_column_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               // load the origin first, then start the glyph walk or, for a newline, the report
               if (req_ch.start_of_text) begin
                  cursor_x_in = req_ch.origin_x;
                  cursor_y_in = req_ch.origin_y;
                  line_x_in   = req_ch.origin_x;
               end
               newline_in = (req_ch.character == NEWLINE_CODE);
               shape_in   = glyph_sel;
               ink_in     = req_ch.ink_color;
               col_in     = '0;
               row_in     = '0;
               sub_in     = '0;
               state_in   = (req_ch.character == NEWLINE_CODE) ? ST_REPORT : ST_DRAW;
            end
         end
         ST_DRAW: begin
            if (can_emit) begin
               if (shape_ff[0] && pix_hit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_PIXEL;
                  rsp_addr_in   = pix_addr;
                  rsp_color_in  = ink_ff;
                  rsp_column_in = '0;
                  rsp_last_in   = 1'b0;
               end
               if (step_done) begin
                  // advance to the next glyph bit, row by row
                  sub_in   = '0;
                  shape_in = shape_ff >> 1;
                  if (col_ff == 2'd2) begin
                     col_in = '0;
                     row_in = row_ff + 3'd1;
                  end else begin
                     col_in = col_ff + 2'd1;
                  end
                  if (row_ff == 3'd4 && col_ff == 2'd2) begin
                     state_in = ST_REPORT;
                  end
               end else begin
                  sub_in = sub_ff + 2'd1;
               end
            end
         end
         ST_REPORT: begin
            if (can_emit) begin
               if (newline_ff) begin
                  cursor_x_in   = line_x_ff;
                  cursor_y_in   = sat_y;
                  rsp_column_in = line_x_ff;
               end else begin
                  cursor_x_in   = sat_x;
                  rsp_column_in = sat_x;
               end
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_CURSOR;
               rsp_addr_in  = '0;
               rsp_color_in = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         line_x_ff    <= '0;
         newline_ff   <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         sub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= RST_TARGET_WIDTH;
         height_ff    <= RST_TARGET_HEIGHT;
         double_ff    <= 1'b0;
         cell_w_ff    <= RST_CELL_WIDTH;
         cell_h_ff    <= RST_CELL_HEIGHT;
      end else begin
         state_ff     <= state_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         line_x_ff    <= line_x_in;
         newline_ff   <= newline_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            unique case (csr_ch.addr)
               REG_TARGET_WIDTH:  width_ff  <= csr_ch.wdata;
               REG_TARGET_HEIGHT: height_ff <= csr_ch.wdata;
               REG_DOUBLE_SIZE:   double_ff <= csr_ch.wdata[0];
               REG_CELL_WIDTH:    cell_w_ff <= csr_ch.wdata[4:0];
               REG_CELL_HEIGHT:   cell_h_ff <= csr_ch.wdata[4:0];
               default: begin
                  // drop writes to unmapped indexes
               end
            endcase
         end
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      shape_ff      <= shape_in;
      ink_ff        <= ink_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_column_ff <= rsp_column_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // a taken request closes the intake until its report is loaded
   `ASSERT_NEXT(a_busy_after_accept, req_ch.valid && req_ch.ready, !req_ch.ready)
   // loading the closing report leaves the writer idle
   `ASSERT_NEXT(a_idle_after_report, (state_ff == ST_REPORT) && can_emit, req_ch.ready)
   // 2x2 sub-pixel steps only occur at double size
   `ASSERT_IMPL(a_sub_double, sub_ff != 2'd0, double_ff)
   // pixel writes never carry the end mark
   `ASSERT_IMPL(a_pixel_not_last, rsp_ch.valid && (rsp_ch.kind == KIND_PIXEL), !rsp_ch.last)

endmodule

`default_nettype wire

// ===== bench/btpw_text_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// btpw_text_checker
// Watches the request, result and register channels of the text pixel
// writer. It keeps its own cursor and register copy and renders every
// accepted request into the pixel writes and the cursor report it should
// cause. Each result is then checked against the oldest of them.
// ----------------------------------------------------------------------------

module btpw_text_checker import btpw_pkg::*; #(
   parameter int unsigned GLYPH_COUNT = 128
) (
   input  wire logic   clock,
   input  wire logic   reset,
   btpw_req_if         req_ch,
   btpw_rsp_if         rsp_ch,
   btpw_csr_if         csr_ch,
   output int unsigned mismatches,
   output int unsigned results_pending
);

   typedef struct packed {
      logic         kind;
      pix_addr_type pixel_address;
      color_type    pixel_color;
      coord_type    cursor_column;
      logic         last;
   } pixel_op_t;

   localparam logic [15:0] SOLID_GLYPH = 16'h7fff;

   // 3x5 font, bit 3*row+col, col 0 leftmost
   localparam logic [15:0] FONT_3X5 [128] = '{
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h2092, 16'h002d, 16'h5f7d, 16'h2f9f, 16'h52a5, 16'h7adb, 16'h0012,
      16'h224a, 16'h2922, 16'h55d5, 16'h05d0, 16'h1400, 16'h01c0, 16'h2000, 16'h1494,
      16'h7b6f, 16'h7493, 16'h73e7, 16'h79a7, 16'h49ed, 16'h79cf, 16'h7bc9, 16'h4927,
      16'h7bef, 16'h49ef, 16'h0410, 16'h1410, 16'h4454, 16'h0e38, 16'h1511, 16'h21a7,
      16'h636a, 16'h5bef, 16'h7aef, 16'h624e, 16'h7b6b, 16'h72cf, 16'h12cf, 16'h7a4e,
      16'h5bed, 16'h7497, 16'h3497, 16'h5aed, 16'h7249, 16'h5b7f, 16'h5b6b, 16'h3b6e,
      16'h13ef, 16'h676a, 16'h5aef, 16'h39ce, 16'h2497, 16'h6b6d, 16'h2b6d, 16'h7f6d,
      16'h5aad, 16'h79ed, 16'h72a7, 16'h324b, 16'h4491, 16'h6926, 16'h002a, 16'h7000,
      16'h0022, 16'h5f78, 16'h7ad8, 16'h7278, 16'h3b58, 16'h72f8, 16'h12f8, 16'h7a78,
      16'h5f68, 16'h74b8, 16'h34b8, 16'h5ae8, 16'h7248, 16'h5bf8, 16'h5b58, 16'h3b70,
      16'h1f78, 16'h6750, 16'h5778, 16'h3870, 16'h24b8, 16'h6b68, 16'h2f68, 16'h7f68,
      16'h5aa8, 16'h79e8, 16'h7338, 16'h64d6, 16'h2492, 16'h3593, 16'h03e0, 16'h0550
   };

   dim_type     fb_width  = RST_TARGET_WIDTH;
   dim_type     fb_height = RST_TARGET_HEIGHT;
   logic        dbl_mode  = 1'b0;
   cell_type    cell_w    = RST_CELL_WIDTH;
   cell_type    cell_h    = RST_CELL_HEIGHT;
   coord_type   pen_x     = '0;
   coord_type   pen_y     = '0;
   coord_type   margin_x  = '0;
   pixel_op_t   pixel_ops [$];
   int unsigned error_count = 0;

   function automatic coord_type clamp16(input int v);
      if (v > 32767) return coord_type'(32767);
      if (v < -32768) return coord_type'(-32768);
      return coord_type'(v);
   endfunction

   // Queue one pixel write unless it falls outside the target.
   function automatic void plot(input int x, input int y, input color_type ink);
      pixel_op_t op;
      if (x < 0 || y < 0 || x >= int'(fb_width) || y >= int'(fb_height)) return;
      op = '0;
      op.kind          = KIND_PIXEL;
      op.pixel_address = pix_addr_type'(y * int'(fb_width) + x);
      op.pixel_color   = ink;
      pixel_ops.push_back(op);
   endfunction

   function automatic void render_char(input logic sot, input coord_type ox,
                                       input coord_type oy, input color_type ink,
                                       input logic [7:0] code);
      int          scale;
      int          bx;
      int          by;
      logic [15:0] shape;
      pixel_op_t   report;
      scale = dbl_mode ? 2 : 1;
      if (sot) begin
         pen_x    = ox;
         pen_y    = oy;
         margin_x = ox;
      end
      if (code == NEWLINE_CODE) begin
         pen_x = margin_x;
         pen_y = clamp16(int'(pen_y) + int'(cell_h) * scale);
      end else begin
         if (code < GLYPH_COUNT) shape = (code < 128) ? FONT_3X5[code[6:0]] : '0;
         else shape = SOLID_GLYPH;
         for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 3; c++) begin
               if (shape[3 * r + c]) begin
                  bx = int'(pen_x) + c * scale;
                  by = int'(pen_y) + r * scale;
                  plot(bx, by, ink);
                  if (scale == 2) begin
                     plot(bx + 1, by, ink);
                     plot(bx, by + 1, ink);
                     plot(bx + 1, by + 1, ink);
                  end
               end
            end
         end
         pen_x = clamp16(int'(pen_x) + int'(cell_w) * scale);
      end
      report = '0;
      report.kind          = KIND_CURSOR;
      report.cursor_column = pen_x;
      report.last          = 1'b1;
      pixel_ops.push_back(report);
   endfunction

   function automatic void flag(input string what, input pixel_op_t want,
                                input pixel_op_t seen);
      if (error_count < 10)
         $display("%0t %s (expected/actual): kind %0d/%0d addr %0d/%0d color %h/%h",
                  $realtime, what, want.kind, seen.kind, want.pixel_address,
                  seen.pixel_address, want.pixel_color, seen.pixel_color,
                  " column %0d/%0d last %0d/%0d", want.cursor_column,
                  seen.cursor_column, want.last, seen.last);
      error_count++;
   endfunction

   always @(posedge clock) begin
      pixel_op_t want;
      pixel_op_t seen;
      if (reset) begin
         fb_width  = RST_TARGET_WIDTH;
         fb_height = RST_TARGET_HEIGHT;
         dbl_mode  = 1'b0;
         cell_w    = RST_CELL_WIDTH;
         cell_h    = RST_CELL_HEIGHT;
         pen_x     = '0;
         pen_y     = '0;
         margin_x  = '0;
         pixel_ops.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.addr)
               REG_TARGET_WIDTH:  fb_width  = csr_ch.wdata;
               REG_TARGET_HEIGHT: fb_height = csr_ch.wdata;
               REG_DOUBLE_SIZE:   dbl_mode  = csr_ch.wdata[0];
               REG_CELL_WIDTH:    cell_w    = csr_ch.wdata[4:0];
               REG_CELL_HEIGHT:   cell_h    = csr_ch.wdata[4:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            render_char(req_ch.start_of_text, req_ch.origin_x, req_ch.origin_y,
                        req_ch.ink_color, req_ch.character);
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.kind          = rsp_ch.kind;
            seen.pixel_address = rsp_ch.pixel_address;
            seen.pixel_color   = rsp_ch.pixel_color;
            seen.cursor_column = rsp_ch.cursor_column;
            seen.last          = rsp_ch.last;
            if (pixel_ops.size() == 0) begin
               flag("unexpected result", '0, seen);
            end else begin
               want = pixel_ops.pop_front();
               if (seen !== want) flag("result mismatch", want, seen);
            end
         end
      end
      results_pending <= pixel_ops.size();
      mismatches      <= error_count;
   end

endmodule

// ===== bench/bitmap_text_pixel_writer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_text_pixel_writer_top_tb
// Drives character requests and register writes into the text pixel writer
// while the receiver stalls at random. A directed run covers the glyph table
// edges, unknown codes, newlines, clipping and cursor saturation; random text
// lines follow under several target sizes and cell settings. The checker
// beside the block predicts every pixel write and cursor report.
// ----------------------------------------------------------------------------

module bitmap_text_pixel_writer_top_tb;
   import btpw_pkg::*;

   localparam int unsigned GLYPH_COUNT     = 128;
   // Longest legal quiet stretch is the longest sender gap or receiver stall
   // on top of a full glyph walk; leave plenty of margin.
   localparam int unsigned QUIET_LIMIT     = 2000;
   localparam int unsigned SETTLE_CYCLES   = 70;
   localparam int unsigned PHASES          = 8;
   localparam int unsigned ITEMS_PER_PHASE = 45;

   logic        clock;
   logic        reset = 1'b1;
   logic        rsp_take = 1'b0;
   bit          calm = 1'b0;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned check_fails;
   int unsigned results_pending;
   int unsigned cfg_w = RST_TARGET_WIDTH;
   int unsigned cfg_h = RST_TARGET_HEIGHT;

   btpw_req_if req_ch ();
   btpw_rsp_if rsp_ch ();
   btpw_csr_if csr_ch ();

   assign rsp_ch.ready = rsp_take;

   bitmap_text_pixel_writer_top #(.GLYPH_COUNT(GLYPH_COUNT)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   btpw_text_checker #(.GLYPH_COUNT(GLYPH_COUNT)) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_ch          (csr_ch),
      .mismatches      (check_fails),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then a long one. Calm phases
   // run with no gaps at all.
   function automatic int unsigned idle_len();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: take results, but stall at random so that back pressure
   // lands on every step of the glyph walk.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_take   <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_take <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) stall_left <= idle_len();
      end
   end

   // Watchdog: end the run if nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL bitmap_text_pixel_writer_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Send one request. Valid stays high on return, so a following request
   // with no gap goes out back to back; callers drop valid before any pause.
   task automatic send_char(input logic sot, input int ox, input int oy,
                            input color_type ink, input logic [7:0] code);
      int unsigned gap;
      gap = idle_len();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.start_of_text <= sot;
      req_ch.origin_x      <= coord_type'(ox);
      req_ch.origin_y      <= coord_type'(oy);
      req_ch.ink_color     <= ink;
      req_ch.character     <= code;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Hold until every predicted result has come back.
   task automatic wait_drained();
      do @(posedge clock); while (results_pending != 0);
   endtask

   // Drain the writer, then rewrite all five registers back to back.
   task automatic write_settings(input int unsigned tw, input int unsigned th,
                                 input int unsigned dbl, input int unsigned cw,
                                 input int unsigned chgt);
      csr_addr_type idx [5];
      int unsigned  val [5];
      idx = '{REG_TARGET_WIDTH, REG_TARGET_HEIGHT, REG_DOUBLE_SIZE,
              REG_CELL_WIDTH, REG_CELL_HEIGHT};
      val = '{tw, th, dbl, cw, chgt};
      req_ch.valid <= 1'b0;
      wait_drained();
      csr_ch.valid <= 1'b1;
      for (int i = 0; i < 5; i++) begin
         csr_ch.addr  <= idx[i];
         csr_ch.wdata <= csr_data_type'(val[i]);
         do @(posedge clock); while (!csr_ch.ready);
      end
      csr_ch.valid <= 1'b0;
      cfg_w = tw;
      cfg_h = th;
   endtask

   // Origin coordinate: mostly around the target so glyphs land partly on
   // and partly off it, sometimes anywhere, sometimes at the 16-bit limits.
   function automatic int pick_origin(input int unsigned span);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return int'($urandom_range(0, span + 14)) - 10;
      if (r < 85) return int'($urandom_range(0, 65535)) - 32768;
      if (r < 93) return 32767 - int'($urandom_range(0, 40));
      return -32768 + int'($urandom_range(0, 40));
   endfunction

   // Character: mostly printable text, some newlines, control and high codes.
   function automatic logic [7:0] pick_char();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 8'($urandom_range(32, 126));
      if (r < 80) return NEWLINE_CODE;
      if (r < 88) return 8'($urandom_range(0, 31));
      return 8'($urandom_range(128, 255));
   endfunction

   initial begin
      int unsigned n_sent;
      int unsigned line_len;
      logic        sot;

      req_ch.valid         <= 1'b0;
      req_ch.start_of_text <= 1'b0;
      req_ch.origin_x      <= '0;
      req_ch.origin_y      <= '0;
      req_ch.ink_color     <= '0;
      req_ch.character     <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.addr          <= REG_TARGET_WIDTH;
      csr_ch.wdata         <= '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings: 128x128, single size, 4x6 cells.
      send_char(1'b1, 0, 0, 16'hffff, 8'd65);              // 'A' at origin
      send_char(1'b0, 0, 0, 16'h0000, 8'd0);               // code zero is a blank
      send_char(1'b0, 0, 0, 16'h5555, 8'd127);             // last ROM entry
      send_char(1'b0, 0, 0, 16'haaaa, 8'd128);             // first unknown code
      send_char(1'b0, 0, 0, 16'h1234, 8'd255);             // last unknown code
      send_char(1'b0, 0, 0, 16'h0001, NEWLINE_CODE);
      send_char(1'b0, 0, 0, 16'h8000, 8'd48);              // '0'
      send_char(1'b1, 126, 125, 16'h8001, 8'd255);         // clip right and bottom
      send_char(1'b1, -1, -2, 16'h7ffe, 8'd255);           // clip left and top
      send_char(1'b1, -32768, -32768, 16'h00ff, 8'd87);    // fully off target
      send_char(1'b0, 0, 0, 16'hff00, NEWLINE_CODE);
      send_char(1'b1, 32767, 32767, 16'h0f0f, 8'd255);     // column saturates
      send_char(1'b0, 0, 0, 16'hf0f0, NEWLINE_CODE);       // row saturates
      send_char(1'b1, 5, 7, 16'h3c3c, NEWLINE_CODE);       // start on a newline
      send_char(1'b0, 0, 0, 16'hc3c3, 8'd126);

      // Largest target, double size, 16x16 cells.
      write_settings(512, 512, 1, 16, 16);
      send_char(1'b1, 506, 505, 16'hbeef, 8'd255);         // 2x2 blocks clipped
      send_char(1'b0, 0, 0, 16'h4242, 8'd35);              // '#'
      send_char(1'b1, 32760, 0, 16'h2424, 8'd65);          // double advance saturates
      send_char(1'b0, 0, 0, 16'h1111, NEWLINE_CODE);
      send_char(1'b1, 0, 32767, 16'h2222, NEWLINE_CODE);

      // Smallest target and cells: at most one pixel survives.
      write_settings(1, 1, 0, 1, 1);
      send_char(1'b1, 0, 0, 16'h9999, 8'd255);
      send_char(1'b0, 0, 0, 16'h6666, 8'd65);
      send_char(1'b0, 0, 0, 16'h7777, NEWLINE_CODE);

      // Random text lines, one register setting per phase. The first and
      // last phases run with no idling on either side.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: write_settings(512, 512, 1, 16, 16);
            1: write_settings(1, 1, 0, 1, 1);
            2: write_settings(40, 30, 0, 4, 6);
            3: write_settings(64, 48, 1, 3, 7);
            4: write_settings(512, 1, 1, 16, 1);
            5: write_settings(1, 512, 0, 1, 16);
            default: write_settings($urandom_range(1, 512), $urandom_range(1, 512),
                                    $urandom_range(0, 1), $urandom_range(1, 16),
                                    $urandom_range(1, 16));
         endcase
         calm   = (p == 0 || p == PHASES - 1);
         n_sent = 0;
         while (n_sent < ITEMS_PER_PHASE) begin
            line_len = $urandom_range(1, 12);
            for (int i = 0; i < line_len && n_sent < ITEMS_PER_PHASE; i++) begin
               // a line opens with a start flag; a stray one now and then
               sot = (i == 0) || ($urandom_range(0, 19) == 0);
               send_char(sot, pick_origin(cfg_w), pick_origin(cfg_h),
                         color_type'($urandom_range(0, 65535)), pick_char());
               n_sent++;
            end
            // Occasionally hold the sender until the writer has fully drained.
            if ($urandom_range(0, 15) == 0) begin
               req_ch.valid <= 1'b0;
               wait_drained();
            end
         end
      end
      calm = 1'b0;

      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (check_fails == 0) begin
         $display("PASS bitmap_text_pixel_writer_top");
      end else begin
         $display("FAIL bitmap_text_pixel_writer_top");
      end
      $finish;
   end

endmodule
